FILE: sv/icpa_pkg.sv
package icpa_pkg;

   // Point and store geometry.
   localparam int CoordWidth   = 24;
   localparam int PointWidth   = 3 * CoordWidth;
   localparam int MaxPoints    = 1024;
   localparam int IndexWidth   = $clog2(MaxPoints);
   localparam int CountWidth   = IndexWidth + 1;

   // Stream payload widths.
   localparam int OpWidth      = 2;
   localparam int ReqDataWidth = PointWidth;
   localparam int RspBits      = 3 * CoordWidth + 23 + 17 + 1;
   localparam int RspDataWidth = ((RspBits + 7) / 8) * 8;

   // Arithmetic widths.
   localparam int ShiftPtWidth = CoordWidth + 1;
   localparam int DeltaWidth   = CoordWidth + 2;
   localparam int SquareWidth  = 2 * DeltaWidth - 2;
   localparam int DistWidth    = SquareWidth + 2;
   localparam int RadiusWidth  = 23;
   localparam int Radius2Width = 2 * RadiusWidth;
   localparam int SumWidth     = ShiftPtWidth + IndexWidth + 1;
   localparam int DivWidth     = Radius2Width + IndexWidth;
   localparam int RmsWidth     = 23;
   localparam int FitWidth     = 17;
   localparam int FitFrac      = 16;
   localparam int LimitWidth   = 8;
   localparam int MinPairs     = 3;

   // Division jobs issued per iteration.
   localparam logic [2:0] DivErr = 3'd3;
   localparam logic [2:0] DivFit = 3'd4;

   typedef enum logic [OpWidth-1:0] {
      OP_CLEAR = 2'd0,
      OP_SRC   = 2'd1,
      OP_TGT   = 2'd2,
      OP_RUN   = 2'd3
   } op_type;

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_START = 14'b00000000000010,
      ST_R2    = 14'b00000000000100,
      ST_SRD   = 14'b00000000001000,
      ST_SLOAD = 14'b00000000010000,
      ST_TRD   = 14'b00000000100000,
      ST_TMUL  = 14'b00000001000000,
      ST_TCMP  = 14'b00000010000000,
      ST_PAIR  = 14'b00000100000000,
      ST_ITEND = 14'b00001000000000,
      ST_DIV   = 14'b00010000000000,
      ST_DWAIT = 14'b00100000000000,
      ST_SWAIT = 14'b01000000000000,
      ST_OUT   = 14'b10000000000000
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DivWidth-1:0]   dividend;
      logic [CountWidth-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [DivWidth-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                   start;
      logic [Radius2Width-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [RmsWidth-1:0] root;
   } sqrt_rsp_type;

endpackage

FILE: sv/icpa_store.sv
module icpa_store (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [icpa_pkg::IndexWidth-1:0] wr_addr,
   input  logic [icpa_pkg::PointWidth-1:0] wr_data,
   input  logic                            rd_en,
   input  logic [icpa_pkg::IndexWidth-1:0] rd_addr,
   output logic [icpa_pkg::PointWidth-1:0] rd_data
);
   import icpa_pkg::*;

   logic [PointWidth-1:0] mem [MaxPoints];
   logic [PointWidth-1:0] rd_data_ff;

   // One write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // One registered read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/icpa_divider.sv
module icpa_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  icpa_pkg::div_req_type div_req,
   output icpa_pkg::div_rsp_type div_rsp
);
   import icpa_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [5:0]            cnt_ff;
   logic [DivWidth-1:0]   quo_ff;
   logic [CountWidth-1:0] rem_ff;
   logic [CountWidth-1:0] dvs_ff;
   logic [CountWidth:0]   trial;
   logic [CountWidth:0]   diff;
   logic                  ge;

   // Restoring division, one quotient bit per cycle.
   assign trial = {rem_ff, quo_ff[DivWidth-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= div_req.dividend;
            rem_ff  <= '0;
            dvs_ff  <= div_req.divisor;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[DivWidth-2:0], ge};
            rem_ff <= ge ? diff[CountWidth-1:0] : trial[CountWidth-1:0];
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(DivWidth - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: sv/icpa_isqrt.sv
module icpa_isqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  icpa_pkg::sqrt_req_type sqrt_req,
   output icpa_pkg::sqrt_rsp_type sqrt_rsp
);
   import icpa_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic [4:0]              cnt_ff;
   logic [Radius2Width-1:0] rad_ff;
   logic [RmsWidth:0]       rem_ff;
   logic [RmsWidth-1:0]     root_ff;
   logic [RmsWidth+2:0]     cur;
   logic [RmsWidth+2:0]     trial;
   logic                    ge;

   // Digit-by-digit square root, one root bit per cycle.
   assign cur   = {rem_ff, rad_ff[Radius2Width-1 -: 2]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign ge    = cur >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (sqrt_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rad_ff  <= sqrt_req.radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            rad_ff  <= {rad_ff[Radius2Width-3:0], 2'b00};
            rem_ff  <= ge ? (RmsWidth+1)'(cur - trial) : cur[RmsWidth:0];
            root_ff <= {root_ff[RmsWidth-2:0], ge};
            cnt_ff  <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(RmsWidth - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sqrt_rsp.busy = busy_ff;
   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = root_ff;

endmodule

FILE: sv/translation_icp_aligner.sv
// Channel  | Direction | Beat contents
// req_     | in        | tuser: opcode; tdata: coord_x, coord_y, coord_z
// rsp_     | out       | tdata: shift_x/y/z, inlier_rms_error, fitness_ratio, converged
// csr_     | in/out    | APB registers: iteration_limit at 0x0, match_radius at 0x4
//
// Clear and append beats are accepted while idle and leave the block idle.
// A run over Ns source and Nt target points, for L iterations, uses one shared squarer for
// every distance, one axis of each pair of points at a time, and one shared serial divider
// for every quotient.
// Reset is synchronous and clears both point counts and the registers to defaults.
// The request side is not ready during a run; a finished result waits in the output
// register and a new run cannot finish until it is taken.
module translation_icp_aligner (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [icpa_pkg::ReqDataWidth-1:0]  req_tdata,  // coord_x, coord_y, coord_z
   input  logic [icpa_pkg::OpWidth-1:0]       req_tuser,  // opcode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // shift_x, shift_y, shift_z, inlier_rms_error, fitness_ratio, converged, zero fill
   output logic [icpa_pkg::RspDataWidth-1:0]  rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [2:0]                         csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import icpa_pkg::*;

   state_type state_ff, state_in;

   logic [LimitWidth-1:0]  limit_ff;
   logic [RadiusWidth-1:0] radius_ff;

   logic [CountWidth-1:0]  src_cnt_ff, tgt_cnt_ff;
   logic [CountWidth-1:0]  src_idx_ff, tgt_idx_ff;
   logic [LimitWidth-1:0]  iter_ff;
   logic [1:0]             axis_ff;
   logic [2:0]             dsel_ff;

   logic signed [ShiftPtWidth-1:0] pnt_ff [3];
   logic signed [CoordWidth-1:0]   trans_ff [3];
   logic signed [CoordWidth-1:0]   best_t_ff [3];
   logic signed [SumWidth-1:0]     ssum_ff [3];
   logic signed [SumWidth-1:0]     tsum_ff [3];
   logic [DistWidth-1:0]           best_ff, acc_ff;
   logic [SquareWidth-1:0]         sq_ff;
   logic [Radius2Width-1:0]        r2_ff;
   logic [CountWidth-1:0]          pairs_ff;
   logic [DivWidth-1:0]            err_ff;
   logic [RmsWidth-1:0]            rms_ff;
   logic [FitWidth-1:0]            fit_ff;
   logic                           conv_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [RspDataWidth-1:0]        rsp_data_ff;

   logic                     req_fire, csr_wr;
   op_type                   req_op;
   logic                     src_we, tgt_we;
   logic [PointWidth-1:0]    src_rd, tgt_rd;
   logic signed [CoordWidth-1:0] scoord [3];
   logic signed [CoordWidth-1:0] tcoord [3];
   logic signed [DeltaWidth-1:0] sq_op;
   logic signed [2*DeltaWidth-1:0] sq_full;
   logic [DistWidth-1:0]     d2;
   logic                     keep;
   logic signed [SumWidth-1:0] sdiff;
   logic [SumWidth-1:0]      smag;
   logic signed [SumWidth:0] step;
   logic signed [SumWidth+1:0] tsat;
   logic                     out_load;
   logic [RspBits-1:0]       rsp_pack;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = state_ff == ST_IDLE;
   assign req_op     = op_type'(req_tuser);

   // Configuration registers.
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? {9'd0, radius_ff} : {24'd0, limit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= LimitWidth'(30);
         radius_ff <= RadiusWidth'(1024);
      end else if (csr_wr) begin
         if (csr_paddr[2]) begin
            radius_ff <= csr_pwdata[RadiusWidth-1:0];
         end else begin
            limit_ff <= csr_pwdata[LimitWidth-1:0];
         end
      end
   end

   // Point stores.
   assign src_we = req_fire && req_op == OP_SRC && src_cnt_ff < CountWidth'(MaxPoints);
   assign tgt_we = req_fire && req_op == OP_TGT && tgt_cnt_ff < CountWidth'(MaxPoints);

   icpa_store u_src_store (
      .clock   (clock),
      .wr_en   (src_we),
      .wr_addr (src_cnt_ff[IndexWidth-1:0]),
      .wr_data (req_tdata),
      .rd_en   (state_ff == ST_SRD),
      .rd_addr (src_idx_ff[IndexWidth-1:0]),
      .rd_data (src_rd)
   );

   icpa_store u_tgt_store (
      .clock   (clock),
      .wr_en   (tgt_we),
      .wr_addr (tgt_cnt_ff[IndexWidth-1:0]),
      .wr_data (req_tdata),
      .rd_en   (state_ff == ST_TRD),
      .rd_addr (tgt_idx_ff[IndexWidth-1:0]),
      .rd_data (tgt_rd)
   );

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         scoord[k] = signed'(src_rd[k*CoordWidth +: CoordWidth]);
         tcoord[k] = signed'(tgt_rd[k*CoordWidth +: CoordWidth]);
      end
   end

   // Shared squarer: the radius once per run, then one axis difference per cycle.
   always_comb begin
      if (state_ff == ST_TMUL) begin
         sq_op = DeltaWidth'(pnt_ff[axis_ff]) - DeltaWidth'(tcoord[axis_ff]);
      end else begin
         sq_op = signed'(DeltaWidth'(radius_ff));
      end
   end
   assign sq_full = sq_op * sq_op;

   always_ff @(posedge clock) begin
      sq_ff <= sq_full[SquareWidth-1:0];
   end

   assign d2   = acc_ff + DistWidth'(sq_ff);
   assign keep = best_ff <= DistWidth'(r2_ff);

   // Divider operand selection and signed step recovery.
   assign sdiff = tsum_ff[dsel_ff[1:0]] - ssum_ff[dsel_ff[1:0]];
   assign smag  = sdiff[SumWidth-1] ? SumWidth'(-sdiff) : SumWidth'(sdiff);
   always_comb begin
      div_req.start = state_ff == ST_DIV;
      case (dsel_ff)
         DivErr: begin
            div_req.dividend = err_ff;
            div_req.divisor  = pairs_ff;
         end
         DivFit: begin
            div_req.dividend = DivWidth'({pairs_ff, FitFrac'(0)});
            div_req.divisor  = src_cnt_ff;
         end
         default: begin
            div_req.dividend = DivWidth'(smag);
            div_req.divisor  = pairs_ff;
         end
      endcase
   end
   assign step = sdiff[SumWidth-1] ? -signed'({1'b0, div_rsp.quotient[SumWidth-1:0]})
                                   : signed'({1'b0, div_rsp.quotient[SumWidth-1:0]});
   assign tsat = (SumWidth+2)'(trans_ff[dsel_ff[1:0]]) + (SumWidth+2)'(step);

   assign sqrt_req.start    = state_ff == ST_DWAIT && div_rsp.done && dsel_ff == DivErr;
   assign sqrt_req.radicand = div_rsp.quotient[Radius2Width-1:0];

   icpa_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   icpa_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_op == OP_RUN) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (src_cnt_ff == '0 || tgt_cnt_ff == '0 || limit_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_R2;
            end
         end
         ST_R2:    state_in = ST_SRD;
         ST_SRD:   state_in = ST_SLOAD;
         ST_SLOAD: state_in = ST_TRD;
         ST_TRD:   state_in = ST_TMUL;
         ST_TMUL: begin
            if (axis_ff == 2'd2) begin
               state_in = ST_TCMP;
            end
         end
         ST_TCMP: begin
            if (tgt_idx_ff + 1'b1 == tgt_cnt_ff) begin
               state_in = ST_PAIR;
            end else begin
               state_in = ST_TRD;
            end
         end
         ST_PAIR: begin
            if (src_idx_ff + 1'b1 == src_cnt_ff) begin
               state_in = ST_ITEND;
            end else begin
               state_in = ST_SRD;
            end
         end
         ST_ITEND: begin
            if (pairs_ff < CountWidth'(MinPairs)) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: state_in = ST_DWAIT;
         ST_DWAIT: begin
            if (div_rsp.done) begin
               if (dsel_ff == DivErr) begin
                  state_in = ST_SWAIT;
               end else if (dsel_ff == DivFit) begin
                  if (iter_ff + 1'b1 == limit_ff) begin
                     state_in = ST_OUT;
                  end else begin
                     state_in = ST_SRD;
                  end
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_SWAIT: begin
            if (sqrt_rsp.done) begin
               state_in = ST_DIV;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_load     = state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_cnt_ff   <= '0;
         tgt_cnt_ff   <= '0;
         src_idx_ff   <= '0;
         pairs_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire && req_op == OP_CLEAR) begin
            src_cnt_ff <= '0;
            tgt_cnt_ff <= '0;
         end
         if (src_we) begin
            src_cnt_ff <= src_cnt_ff + 1'b1;
         end
         if (tgt_we) begin
            tgt_cnt_ff <= tgt_cnt_ff + 1'b1;
         end
         case (state_ff)
            ST_START: begin
               src_idx_ff <= '0;
               pairs_ff   <= '0;
            end
            ST_PAIR: begin
               src_idx_ff <= src_idx_ff + 1'b1;
               if (keep) begin
                  pairs_ff <= pairs_ff + 1'b1;
               end
            end
            ST_DWAIT: begin
               if (div_rsp.done && dsel_ff == DivFit) begin
                  src_idx_ff <= '0;
                  pairs_ff   <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_START: begin
            iter_ff <= '0;
            rms_ff  <= '0;
            fit_ff  <= '0;
            conv_ff <= 1'b0;
            err_ff  <= '0;
            for (int k = 0; k < 3; k++) begin
               trans_ff[k] <= '0;
               ssum_ff[k]  <= '0;
               tsum_ff[k]  <= '0;
            end
         end
         ST_R2: begin
            r2_ff <= sq_ff[Radius2Width-1:0];
         end
         ST_SLOAD: begin
            tgt_idx_ff <= '0;
            for (int k = 0; k < 3; k++) begin
               pnt_ff[k] <= ShiftPtWidth'(scoord[k]) + ShiftPtWidth'(trans_ff[k]);
            end
         end
         ST_TRD: begin
            axis_ff <= '0;
         end
         ST_TMUL: begin
            axis_ff <= axis_ff + 2'd1;
            if (axis_ff == 2'd0) begin
               acc_ff <= '0;
            end else begin
               acc_ff <= d2;
            end
         end
         ST_TCMP: begin
            tgt_idx_ff <= tgt_idx_ff + 1'b1;
            if (tgt_idx_ff == '0 || d2 < best_ff) begin
               best_ff <= d2;
               for (int k = 0; k < 3; k++) begin
                  best_t_ff[k] <= tcoord[k];
               end
            end
         end
         ST_PAIR: begin
            if (keep) begin
               err_ff <= err_ff + DivWidth'(best_ff);
               for (int k = 0; k < 3; k++) begin
                  ssum_ff[k] <= ssum_ff[k] + SumWidth'(pnt_ff[k]);
                  tsum_ff[k] <= tsum_ff[k] + SumWidth'(best_t_ff[k]);
               end
            end
         end
         ST_ITEND: begin
            dsel_ff <= '0;
         end
         ST_DWAIT: begin
            if (div_rsp.done) begin
               if (dsel_ff == DivFit) begin
                  fit_ff  <= div_rsp.quotient[FitWidth-1:0];
                  conv_ff <= 1'b1;
                  iter_ff <= iter_ff + 1'b1;
                  err_ff  <= '0;
                  for (int k = 0; k < 3; k++) begin
                     ssum_ff[k] <= '0;
                     tsum_ff[k] <= '0;
                  end
               end else if (dsel_ff != DivErr) begin
                  // Step toward the target, saturated to the coordinate range.
                  if (tsat > (SumWidth+2)'(8388607)) begin
                     trans_ff[dsel_ff[1:0]] <= CoordWidth'(8388607);
                  end else if (tsat < -(SumWidth+2)'(8388608)) begin
                     trans_ff[dsel_ff[1:0]] <= CoordWidth'(-8388608);
                  end else begin
                     trans_ff[dsel_ff[1:0]] <= tsat[CoordWidth-1:0];
                  end
                  dsel_ff <= dsel_ff + 3'd1;
               end
            end
         end
         ST_SWAIT: begin
            if (sqrt_rsp.done) begin
               rms_ff  <= sqrt_rsp.root;
               dsel_ff <= DivFit;
            end
         end
         default: begin
         end
      endcase
      if (out_load) begin
         rsp_data_ff <= RspDataWidth'(rsp_pack);
      end
   end

   assign rsp_pack   = {conv_ff, fit_ff, rms_ff, trans_ff[2], trans_ff[1], trans_ff[0]};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks on the run sequencer and the result beat.
   a_fit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[111:95] <= 17'd65536)
      else $error("fitness beyond one");

   a_zero_unconverged: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[112] |-> rsp_tdata[111:0] == '0)
      else $error("nonzero result without a completed iteration");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider restarted while busy");

   a_pairs_bound: assert property (@(posedge clock) disable iff (reset)
      pairs_ff <= src_idx_ff)
      else $error("more pairs than visited source points");

endmodule

FILE: bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import icpa_pkg::*;

   // Register indexes of the configuration port.
   localparam int REG_ITER_LIMIT   = 0;
   localparam int REG_MATCH_RADIUS = 1;
   localparam int CMAX = 8388607;
   localparam int CMIN = -8388608;

   typedef enum int {K_BEAT, K_CSR, K_DRAIN} step_kind_type;

   typedef struct {
      step_kind_type kind;
      op_type        op;
      int            pt[3];
      int            reg_index;
      int            reg_value;
   } step_type;

   typedef struct packed {
      logic [6:0]  fill;
      logic        converged;
      logic [16:0] fitness;
      logic [22:0] rms;
      logic [23:0] sz;
      logic [23:0] sy;
      logic [23:0] sx;
   } pose_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;  // coord_x, coord_y, coord_z
   logic [OpWidth-1:0] req_tuser = '0;       // opcode
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // shift_x, shift_y, shift_z, inlier_rms_error, fitness_ratio, converged, zero fill
   logic [RspDataWidth-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   translation_icp_aligner dut (.*);

   // Software copy of the aligner state.
   int src_pt[MaxPoints][3];
   int tgt_pt[MaxPoints][3];
   int src_n = 0;
   int tgt_n = 0;
   int iter_limit = 30;
   int radius = 1024;

   step_type pending_steps[$];
   pose_type expected_poses[$];
   int errors = 0;
   int beats_done = 0;
   int quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bit_val;
      res = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val >>= 2;
      while (bit_val != 0) begin
         if (v >= res + bit_val) begin
            v -= res + bit_val;
            res = (res >> 1) + bit_val;
         end else begin
            res >>= 1;
         end
         bit_val >>= 2;
      end
      return res;
   endfunction

   // Translation-only alignment of the stored clouds.
   function automatic pose_type icp_align();
      pose_type r;
      longint shift[3];
      longint ssum[3], tsum[3], p[3];
      longint r2, err, best, d2, d, step;
      longint unsigned rms, fit;
      int pairs, bi;
      r = '0;
      shift = '{0, 0, 0};
      if (src_n == 0 || tgt_n == 0) return r;
      r2 = longint'(radius) * longint'(radius);
      for (int it = 0; it < iter_limit; it++) begin
         ssum = '{0, 0, 0};
         tsum = '{0, 0, 0};
         err = 0;
         pairs = 0;
         for (int i = 0; i < src_n; i++) begin
            best = 0;
            bi = 0;
            for (int k = 0; k < 3; k++) p[k] = longint'(src_pt[i][k]) + shift[k];
            for (int j = 0; j < tgt_n; j++) begin
               d2 = 0;
               for (int k = 0; k < 3; k++) begin
                  d = p[k] - longint'(tgt_pt[j][k]);
                  d2 += d * d;
               end
               // Strict compare keeps the lowest index on a tie.
               if (j == 0 || d2 < best) begin
                  best = d2;
                  bi = j;
               end
            end
            if (best <= r2) begin
               pairs++;
               err += best;
               for (int k = 0; k < 3; k++) begin
                  ssum[k] += p[k];
                  tsum[k] += longint'(tgt_pt[bi][k]);
               end
            end
         end
         if (pairs < MinPairs) break;
         for (int k = 0; k < 3; k++) begin
            step = (tsum[k] - ssum[k]) / longint'(pairs);
            shift[k] += step;
            if (shift[k] > CMAX) shift[k] = CMAX;
            if (shift[k] < CMIN) shift[k] = CMIN;
         end
         rms = int_sqrt(longint'(err / pairs));
         if (rms > 64'h7FFFFF) rms = 64'h7FFFFF;
         fit = (longint'(pairs) << 16) / longint'(src_n);
         if (fit > 65536) fit = 65536;
         r.rms = rms[22:0];
         r.fitness = fit[16:0];
         r.converged = 1'b1;
      end
      r.sx = shift[0][23:0];
      r.sy = shift[1][23:0];
      r.sz = shift[2][23:0];
      return r;
   endfunction

   function automatic void apply_beat(step_type s);
      case (s.op)
         OP_CLEAR: begin
            src_n = 0;
            tgt_n = 0;
         end
         OP_SRC: begin
            if (src_n < MaxPoints) begin
               src_pt[src_n] = s.pt;
               src_n++;
            end
         end
         OP_TGT: begin
            if (tgt_n < MaxPoints) begin
               tgt_pt[tgt_n] = s.pt;
               tgt_n++;
            end
         end
         default: expected_poses = {expected_poses, icp_align()};
      endcase
   endfunction

   // Stimulus helpers.
   function automatic void add_beat(op_type op, int x, int y, int z);
      step_type s;
      s.kind = K_BEAT;
      s.op = op;
      s.pt = '{x, y, z};
      pending_steps = {pending_steps, s};
   endfunction

   function automatic void add_csr(int index, int value);
      step_type s;
      s.kind = K_CSR;
      s.op = OP_CLEAR;
      s.pt = '{0, 0, 0};
      s.reg_index = index;
      s.reg_value = value;
      pending_steps = {pending_steps, s};
   endfunction

   function automatic void add_drain();
      step_type s;
      s.kind = K_DRAIN;
      s.op = OP_CLEAR;
      s.pt = '{0, 0, 0};
      pending_steps = {pending_steps, s};
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(32'h00FFFFFF)) - 32'sd8388608;
   endfunction

   function automatic int jitter(int v, int span);
      longint t;
      t = longint'(v) + longint'($urandom_range(2 * span)) - span;
      if (t > CMAX) t = CMAX;
      if (t < CMIN) t = CMIN;
      return int'(t);
   endfunction

   // Directed cases followed by random point clouds.
   initial begin
      int ns, nt, base, off[3], spread, sx, sy, sz, rnd_beats;
      add_beat(OP_RUN, 0, 0, 0);
      add_beat(OP_SRC, CMAX, CMIN, CMAX);
      add_beat(OP_SRC, CMIN, CMAX, -1);
      add_beat(OP_RUN, CMAX, CMAX, CMAX);
      add_beat(OP_TGT, 0, 0, 0);
      add_csr(REG_ITER_LIMIT, 0);
      add_beat(OP_RUN, 0, 0, 0);
      // Two sources only: too few pairs.
      add_csr(REG_ITER_LIMIT, 255);
      add_csr(REG_MATCH_RADIUS, CMAX);
      add_beat(OP_RUN, 0, 0, 0);
      // Equidistant targets; the lowest index must win.
      add_beat(OP_CLEAR, 0, 0, 0);
      for (int i = 0; i < 3; i++) add_beat(OP_SRC, 0, i * 512, 0);
      add_beat(OP_TGT, 1024, 0, 0);
      add_beat(OP_TGT, -1024, 0, 0);
      add_csr(REG_MATCH_RADIUS, 2048);
      add_csr(REG_ITER_LIMIT, 4);
      add_beat(OP_RUN, 0, 0, 0);
      // Far apart extreme clouds at the widest radius.
      add_beat(OP_CLEAR, 0, 0, 0);
      add_csr(REG_MATCH_RADIUS, CMAX);
      for (int i = 0; i < 3; i++) add_beat(OP_SRC, CMIN + i, -4194304, CMAX - i);
      for (int i = 0; i < 3; i++) add_beat(OP_TGT, -1, 4194303, -i);
      add_beat(OP_RUN, 0, 0, 0);
      add_csr(REG_MATCH_RADIUS, 0);
      add_beat(OP_RUN, 0, 0, 0);
      add_drain();

      // Random runs over small clouds, mostly matched pairs with noise.
      rnd_beats = 0;
      while (rnd_beats < 860) begin
         if ($urandom_range(3) == 0) begin
            case ($urandom_range(9))
               0: add_csr(REG_ITER_LIMIT, 0);
               1: add_csr(REG_ITER_LIMIT, 255);
               default: add_csr(REG_ITER_LIMIT, $urandom_range(1, 6));
            endcase
            case ($urandom_range(9))
               0: add_csr(REG_MATCH_RADIUS, 0);
               1: add_csr(REG_MATCH_RADIUS, CMAX);
               2: add_csr(REG_MATCH_RADIUS, $urandom_range(CMAX));
               default: add_csr(REG_MATCH_RADIUS, $urandom_range(500, 30000));
            endcase
         end
         if ($urandom_range(4) != 0) begin
            add_beat(OP_CLEAR, rand_coord(), rand_coord(), rand_coord());
            rnd_beats++;
         end
         ns = $urandom_range(7);
         nt = $urandom_range(7);
         base = $urandom_range(1) ? rand_coord() / 2 : int'($urandom_range(20000)) - 10000;
         spread = $urandom_range(1, 20000);
         for (int k = 0; k < 3; k++) off[k] = int'($urandom_range(8000)) - 4000;
         for (int i = 0; i < ns || i < nt; i++) begin
            if ($urandom_range(9) == 0) begin
               sx = rand_coord();
               sy = rand_coord();
               sz = rand_coord();
            end else begin
               sx = jitter(base, spread);
               sy = jitter(base, spread);
               sz = jitter(base, spread);
            end
            if (i < ns) begin
               add_beat(OP_SRC, sx, sy, sz);
               rnd_beats++;
            end
            if (i < nt) begin
               add_beat(OP_TGT, jitter(sx + off[0], 300), jitter(sy + off[1], 300),
                        jitter(sz + off[2], 300));
               rnd_beats++;
            end
         end
         add_beat(OP_RUN, rand_coord(), rand_coord(), rand_coord());
         rnd_beats++;
         if ($urandom_range(19) == 0) add_drain();
      end
   end

   // Request driver and configuration writes.
   always @(posedge clock) begin
      logic nv, n_psel, n_pen;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
      end else begin
         nv = req_tvalid;
         n_psel = csr_psel;
         n_pen = csr_penable;
         if (req_tvalid && req_tready) begin
            apply_beat(pending_steps.pop_front());
            beats_done++;
            nv = 1'b0;
         end
         if (csr_psel) begin
            if (csr_penable) begin
               n_psel = 1'b0;
               n_pen = 1'b0;
            end else begin
               n_pen = 1'b1;
            end
         end else if (!nv && pending_steps.size() > 0) begin
            if (pending_steps[0].kind != K_BEAT) begin
               // Only touch registers once the block has gone quiet.
               if (expected_poses.size() == 0) begin
                  if (quiet_cycles >= 8) begin
                     quiet_cycles <= 0;
                     if (pending_steps[0].kind == K_CSR) begin
                        n_psel = 1'b1;
                        csr_pwrite <= 1'b1;
                        csr_paddr <= 3'(4 * pending_steps[0].reg_index);
                        csr_pwdata <= pending_steps[0].reg_value;
                        if (pending_steps[0].reg_index == REG_ITER_LIMIT) begin
                           iter_limit = pending_steps[0].reg_value & 8'hFF;
                        end else begin
                           radius = pending_steps[0].reg_value & 23'h7FFFFF;
                        end
                     end
                     void'(pending_steps.pop_front());
                  end else begin
                     quiet_cycles <= quiet_cycles + 1;
                  end
               end else begin
                  quiet_cycles <= 0;
               end
            end else if (beats_done inside {[300:500]} || $urandom_range(99) >= 24) begin
               nv = 1'b1;
               req_tuser <= pending_steps[0].op;
               req_tdata <= {24'(pending_steps[0].pt[2]), 24'(pending_steps[0].pt[1]),
                             24'(pending_steps[0].pt[0])};
            end
         end
         req_tvalid <= nv;
         csr_psel <= n_psel;
         csr_penable <= n_pen;
      end
   end

   // Result monitor and back pressure.
   always @(posedge clock) begin
      pose_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (beats_done inside {[300:500]}) || ($urandom_range(99) >= 24);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_poses.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = expected_poses.pop_front();
               if (got.sx !== want.sx || got.sy !== want.sy || got.sz !== want.sz) begin
                  $display("%0t: shift expected %h %h %h actual %h %h %h", $time,
                           want.sx, want.sy, want.sz, got.sx, got.sy, got.sz);
                  errors++;
               end
               if (got.rms !== want.rms) begin
                  $display("%0t: rms expected %0d actual %0d", $time, want.rms, got.rms);
                  errors++;
               end
               if (got.fitness !== want.fitness) begin
                  $display("%0t: fitness expected %0d actual %0d", $time,
                           want.fitness, got.fitness);
                  errors++;
               end
               if (got.converged !== want.converged) begin
                  $display("%0t: converged expected %0b actual %0b", $time,
                           want.converged, got.converged);
                  errors++;
               end
            end
         end
      end
   end

   // Reset, then wait for all beats to drain.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      wait (pending_steps.size() == 0 && !req_tvalid && expected_poses.size() == 0);
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_poses.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: filelist.f
sv/icpa_pkg.sv
sv/icpa_store.sv
sv/icpa_divider.sv
sv/icpa_isqrt.sv
sv/translation_icp_aligner.sv
bench/tb_top.sv
